>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hw/rtl/cwb_pkg.sv
package cwb_pkg;

  localparam int MAX_DIM_DEF = 4096;
  localparam int DIM_W_DEF   = $clog2(MAX_DIM_DEF) + 1;

  localparam int POS_W      = 16;
  localparam int BOX_W      = 13;
  localparam int STRIDE_W   = 15;
  localparam int GRAY_W     = 8;
  localparam int ADDR_W     = 26;
  localparam int DATA_W     = 32;
  localparam int BCNT_W     = 3;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_PIXEL  = 2'd1,
    OP_FRAME  = 2'd2
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE     = 8'd3;

  localparam logic [BOX_W-1:0]    SCREEN_W_RST = 13'd640;
  localparam logic [BOX_W-1:0]    SCREEN_H_RST = 13'd480;
  localparam logic [STRIDE_W-1:0] STRIDE_RST   = 15'd2560;
  localparam logic                WIDE_RST     = 1'b1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  localparam logic [7:0]        ALPHA_OPAQUE = 8'hFF;
  localparam logic [BCNT_W-1:0] BYTES_NARROW = 3'd1;
  localparam logic [BCNT_W-1:0] BYTES_WIDE   = 3'd4;

endpackage

>>> hw/rtl/cwb_ifs.sv
interface cwb_in_if #(
  parameter int DIM_W = cwb_pkg::DIM_W_DEF
);
  import cwb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              op;
  logic signed [POS_W-1:0] win_x;
  logic signed [POS_W-1:0] win_y;
  logic [DIM_W-1:0]        win_w;
  logic [DIM_W-1:0]        win_h;
  logic                    win_dirty;
  logic [GRAY_W-1:0]       gray;

  modport source (output valid, op, win_x, win_y, win_w, win_h, win_dirty, gray,
                  input ready);
  modport sink (input valid, op, win_x, win_y, win_w, win_h, win_dirty, gray,
                output ready);
endinterface

interface cwb_out_if;
  import cwb_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] data;
  logic [BCNT_W-1:0] byte_count;
  logic [BOX_W-1:0]  box_left;
  logic [BOX_W-1:0]  box_top;
  logic [BOX_W-1:0]  box_right;
  logic [BOX_W-1:0]  box_bottom;
  logic              box_empty;
  logic              frame_dirty;

  modport source (output valid, kind, address, data, byte_count, box_left, box_top,
                  box_right, box_bottom, box_empty, frame_dirty, input ready);
  modport sink (input valid, kind, address, data, byte_count, box_left, box_top,
                box_right, box_bottom, box_empty, frame_dirty, output ready);
endinterface

interface cwb_cfg_if;
  import cwb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/clipped_window_blit.sv
// Channel  Role    Handshake    Payload
// in_ch    sink    valid/ready  op, win_x, win_y, win_w, win_h, win_dirty, gray
// out_ch   source  valid/ready  kind, address, data, byte_count, box fields, frame_dirty
// cfg_ch   sink    valid/ready  index, data; ready is always high
//
// One item per cycle sustained while out_ch accepts results; a result passes from the input
// transfer through the input register and then the result register to the output transfer.
// rst_n is synchronous and active low; it restores the control and state registers to their reset values.
// While out_ch is stalled, an item that yields a result waits in the input register and
// in_ch.ready falls; items that yield no result keep flowing.
`include "assert_macros.svh"

module clipped_window_blit #(
  parameter int MAX_DIM = cwb_pkg::MAX_DIM_DEF
) (
  input logic       clk,
  input logic       rst_n,
  cwb_in_if.sink    in_ch,
  cwb_out_if.source out_ch,
  cwb_cfg_if.sink   cfg_ch
);
  import cwb_pkg::*;

  localparam int DW = $clog2(MAX_DIM) + 1;
  localparam int AW = (DW + 2 > 18) ? DW + 2 : 18;
  localparam logic signed [AW-1:0] ZERO = '0;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [POS_W-1:0] win_x;
    logic signed [POS_W-1:0] win_y;
    logic [DW-1:0]           win_w;
    logic [DW-1:0]           win_h;
    logic                    win_dirty;
    logic [GRAY_W-1:0]       gray;
  } item_t;

  function automatic logic signed [AW-1:0] smax(logic signed [AW-1:0] a,
                                                logic signed [AW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [AW-1:0] smin(logic signed [AW-1:0] a,
                                                logic signed [AW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  logic [BOX_W-1:0]    screen_w_r;
  logic [BOX_W-1:0]    screen_h_r;
  logic [STRIDE_W-1:0] stride_r;
  logic                wide_r;

  logic  s1_valid_r;
  item_t s1_r;

  logic signed [POS_W-1:0] origin_x_r;
  logic [ADDR_W-1:0]       row_y_r;
  logic [DW-1:0]           width_now_r, height_now_r;
  logic [DW-1:0]           clip_col_lo_r, clip_col_hi_r, clip_row_lo_r, clip_row_hi_r;
  logic [DW-1:0]           cursor_col_r, cursor_row_r;
  logic [BOX_W-1:0]        box_left_r, box_top_r, box_right_r, box_bottom_r;
  logic                    any_dirty_r;

  logic              out_valid_r;
  logic              out_kind_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [DATA_W-1:0] out_data_r;
  logic [BCNT_W-1:0] out_bcnt_r;
  logic [BOX_W-1:0]  out_left_r, out_top_r, out_right_r, out_bottom_r;
  logic              out_empty_r, out_dirty_r;

  logic out_free, res_needed, proceed, in_fire;
  logic is_pixel, is_frame;

  logic signed [AW-1:0] px, py, pw, ph, sw, sh;
  logic signed [AW-1:0] cx0, cx1, cy0, cy1;
  logic signed [AW-1:0] bl, bt, br, bb;
  logic                 hdr_empty;

  logic              pix_live, in_clip, wrap;
  logic [DW-1:0]     col_inc;
  logic [ADDR_W-1:0] sx, pix_off, row_off, pix_addr;
  logic              frame_empty;

  assign is_pixel  = s1_r.op == OP_PIXEL;
  assign is_frame  = s1_r.op == OP_FRAME;

  assign px = AW'(s1_r.win_x);
  assign py = AW'(s1_r.win_y);
  assign pw = signed'(AW'(s1_r.win_w));
  assign ph = signed'(AW'(s1_r.win_h));
  assign sw = signed'(AW'(screen_w_r));
  assign sh = signed'(AW'(screen_h_r));

  assign cx0 = smax(ZERO, -px);
  assign cx1 = smin(pw, sw - px);
  assign cy0 = smax(ZERO, -py);
  assign cy1 = smin(ph, sh - py);
  assign hdr_empty = (cx0 >= cx1) || (cy0 >= cy1);

  assign bl = smin(signed'(AW'(box_left_r)), smax(ZERO, px));
  assign bt = smin(signed'(AW'(box_top_r)), smax(ZERO, py));
  assign br = smax(signed'(AW'(box_right_r)), smin(sw, px + pw));
  assign bb = smax(signed'(AW'(box_bottom_r)), smin(sh, py + ph));

  assign pix_live = cursor_row_r < height_now_r;
  assign in_clip  = (cursor_col_r >= clip_col_lo_r) && (cursor_col_r < clip_col_hi_r) &&
                    (cursor_row_r >= clip_row_lo_r) && (cursor_row_r < clip_row_hi_r);
  assign col_inc  = cursor_col_r + DW'(1);
  assign wrap     = col_inc >= width_now_r;
  assign sx       = ADDR_W'(origin_x_r) + ADDR_W'(cursor_col_r);
  assign pix_off  = wide_r ? {sx[ADDR_W-3:0], 2'b00} : sx;
  assign row_off  = row_y_r * ADDR_W'(stride_r);
  assign pix_addr = row_off + pix_off;

  assign frame_empty = (box_left_r >= box_right_r) || (box_top_r >= box_bottom_r);

  assign res_needed = is_frame || (is_pixel && pix_live && in_clip);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign proceed    = s1_valid_r && (!res_needed || out_free);
  assign in_ch.ready = !s1_valid_r || proceed;
  assign in_fire    = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r <= SCREEN_W_RST;
      screen_h_r <= SCREEN_H_RST;
      stride_r   <= STRIDE_RST;
      wide_r     <= WIDE_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_SCREEN_W: screen_w_r <= cfg_ch.data[BOX_W-1:0];
        CFG_SCREEN_H: screen_h_r <= cfg_ch.data[BOX_W-1:0];
        CFG_STRIDE:   stride_r   <= cfg_ch.data[STRIDE_W-1:0];
        CFG_WIDE:     wide_r     <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (proceed) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.op        <= in_ch.op;
      s1_r.win_x     <= in_ch.win_x;
      s1_r.win_y     <= in_ch.win_y;
      s1_r.win_w     <= DW'(in_ch.win_w);
      s1_r.win_h     <= DW'(in_ch.win_h);
      s1_r.win_dirty <= in_ch.win_dirty;
      s1_r.gray      <= in_ch.gray;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r    <= '0;
      row_y_r       <= '0;
      width_now_r   <= '0;
      height_now_r  <= '0;
      clip_col_lo_r <= '0;
      clip_col_hi_r <= '0;
      clip_row_lo_r <= '0;
      clip_row_hi_r <= '0;
      cursor_col_r  <= '0;
      cursor_row_r  <= '0;
      box_left_r    <= SCREEN_W_RST;
      box_top_r     <= SCREEN_H_RST;
      box_right_r   <= '0;
      box_bottom_r  <= '0;
      any_dirty_r   <= 1'b0;
    end else if (proceed) begin
      case (s1_r.op)
        OP_HEADER: begin
          origin_x_r   <= s1_r.win_x;
          row_y_r      <= ADDR_W'(s1_r.win_y);
          width_now_r  <= s1_r.win_w;
          height_now_r <= s1_r.win_h;
          if (hdr_empty) begin
            clip_col_lo_r <= '0;
            clip_col_hi_r <= '0;
            clip_row_lo_r <= '0;
            clip_row_hi_r <= '0;
          end else begin
            clip_col_lo_r <= cx0[DW-1:0];
            clip_col_hi_r <= cx1[DW-1:0];
            clip_row_lo_r <= cy0[DW-1:0];
            clip_row_hi_r <= cy1[DW-1:0];
          end
          cursor_col_r <= '0;
          cursor_row_r <= (s1_r.win_w == '0) ? s1_r.win_h : '0;
          box_left_r   <= bl[BOX_W-1:0];
          box_top_r    <= bt[BOX_W-1:0];
          box_right_r  <= br[BOX_W-1:0];
          box_bottom_r <= bb[BOX_W-1:0];
          any_dirty_r  <= any_dirty_r | s1_r.win_dirty;
        end
        OP_PIXEL: begin
          if (pix_live) begin
            if (wrap) begin
              cursor_col_r <= '0;
              cursor_row_r <= cursor_row_r + DW'(1);
              row_y_r      <= row_y_r + ADDR_W'(1);
            end else begin
              cursor_col_r <= col_inc;
            end
          end
        end
        OP_FRAME: begin
          box_left_r   <= screen_w_r;
          box_top_r    <= screen_h_r;
          box_right_r  <= '0;
          box_bottom_r <= '0;
          any_dirty_r  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proceed && res_needed) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && res_needed) begin
      if (is_frame) begin
        out_kind_r   <= KIND_FRAME;
        out_addr_r   <= '0;
        out_data_r   <= '0;
        out_bcnt_r   <= '0;
        out_left_r   <= box_left_r;
        out_top_r    <= box_top_r;
        out_right_r  <= box_right_r;
        out_bottom_r <= box_bottom_r;
        out_empty_r  <= frame_empty;
        out_dirty_r  <= any_dirty_r;
      end else begin
        out_kind_r   <= KIND_PIXEL;
        out_addr_r   <= pix_addr;
        out_data_r   <= wide_r ? {ALPHA_OPAQUE, s1_r.gray, s1_r.gray, s1_r.gray}
                               : DATA_W'(s1_r.gray);
        out_bcnt_r   <= wide_r ? BYTES_WIDE : BYTES_NARROW;
        out_left_r   <= '0;
        out_top_r    <= '0;
        out_right_r  <= '0;
        out_bottom_r <= '0;
        out_empty_r  <= 1'b0;
        out_dirty_r  <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_kind_r;
  assign out_ch.address     = out_addr_r;
  assign out_ch.data        = out_data_r;
  assign out_ch.byte_count  = out_bcnt_r;
  assign out_ch.box_left    = out_left_r;
  assign out_ch.box_top     = out_top_r;
  assign out_ch.box_right   = out_right_r;
  assign out_ch.box_bottom  = out_bottom_r;
  assign out_ch.box_empty   = out_empty_r;
  assign out_ch.frame_dirty = out_dirty_r;

  `ASSERT_CLK(a_cursor_in_window, clk, rst_n, cursor_row_r <= height_now_r, "cursor row beyond window height")
  `ASSERT_CLK(a_clip_in_window, clk, rst_n, (clip_col_hi_r <= width_now_r) && (clip_row_hi_r <= height_now_r), "clip bounds exceed window size")
  `ASSERT_CLK(a_result_lands, clk, rst_n, (proceed && res_needed) |=> out_valid_r, "result lost on its way to the output register")
  `ASSERT_IMPLIES(a_wide_alpha, clk, rst_n, out_valid_r && (out_kind_r == KIND_PIXEL) && (out_bcnt_r == BYTES_WIDE), out_data_r[DATA_W-1:DATA_W-8] == ALPHA_OPAQUE, "wide pixel write without opaque alpha byte")

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cwb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD = 300;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [POS_W-1:0]  win_x;
    logic [POS_W-1:0]  win_y;
    logic [BOX_W-1:0]  win_w;
    logic [BOX_W-1:0]  win_h;
    logic              win_dirty;
    logic [GRAY_W-1:0] gray;
  } blit_item_t;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    logic [BCNT_W-1:0] byte_count;
    logic [BOX_W-1:0]  box_left;
    logic [BOX_W-1:0]  box_top;
    logic [BOX_W-1:0]  box_right;
    logic [BOX_W-1:0]  box_bottom;
    logic              box_empty;
    logic              frame_dirty;
  } blit_result_t;

  logic clk;
  logic rst_n;

  cwb_in_if  in_ch ();
  cwb_out_if out_ch ();
  cwb_cfg_if cfg_ch ();

  clipped_window_blit u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  int scr_w = SCREEN_W_RST;
  int scr_h = SCREEN_H_RST;
  int stride = STRIDE_RST;
  bit wide = WIDE_RST;

  int org_x = 0;
  int org_y = 0;
  int win_cols = 0;
  int win_rows = 0;
  int col_lo = 0;
  int col_hi = 0;
  int row_lo = 0;
  int row_hi = 0;
  int cur_col = 0;
  int cur_row = 0;
  int box_l = SCREEN_W_RST;
  int box_t = SCREEN_H_RST;
  int box_r = 0;
  int box_b = 0;
  bit dirty_seen = 1'b0;

  blit_item_t   items_pending[$];
  blit_item_t   on_bus;
  blit_result_t results_due[$];
  blit_result_t seen;
  blit_result_t wanted;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit recv_hold = 1'b0;
  int mismatches = 0;
  int cycles = 0;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int imin(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  task automatic composite(input blit_item_t it);
    int px, py, pw, ph, cx0, cx1, cy0, cy1, col, row;
    bit in_clip;
    longint sx, sy, addr;
    blit_result_t r;
    r = '0;
    case (it.op)
      OP_HEADER: begin
        px = $signed(it.win_x);
        py = $signed(it.win_y);
        pw = it.win_w;
        ph = it.win_h;
        cx0 = imax(0, -px);
        cx1 = imin(pw, scr_w - px);
        cy0 = imax(0, -py);
        cy1 = imin(ph, scr_h - py);
        org_x = px;
        org_y = py;
        win_cols = pw;
        win_rows = ph;
        if (cx0 >= cx1 || cy0 >= cy1) begin
          col_lo = 0;
          col_hi = 0;
          row_lo = 0;
          row_hi = 0;
        end else begin
          col_lo = cx0;
          col_hi = cx1;
          row_lo = cy0;
          row_hi = cy1;
        end
        cur_col = 0;
        cur_row = (pw == 0) ? ph : 0;
        box_l = imin(box_l, imax(0, px));
        box_t = imin(box_t, imax(0, py));
        box_r = imax(box_r, imin(scr_w, px + pw));
        box_b = imax(box_b, imin(scr_h, py + ph));
        dirty_seen = dirty_seen | it.win_dirty;
      end
      OP_PIXEL: begin
        if (cur_row < win_rows) begin
          col = cur_col;
          row = cur_row;
          in_clip = col >= col_lo && col < col_hi && row >= row_lo && row < row_hi;
          cur_col = col + 1;
          if (cur_col >= win_cols) begin
            cur_col = 0;
            cur_row = row + 1;
          end
          if (in_clip) begin
            sx = org_x + col;
            sy = org_y + row;
            addr = sy * stride + sx * (wide ? 4 : 1);
            r.kind = KIND_PIXEL;
            r.address = addr[ADDR_W-1:0];
            if (wide) begin
              r.data = {ALPHA_OPAQUE, it.gray, it.gray, it.gray};
              r.byte_count = BYTES_WIDE;
            end else begin
              r.data = {24'd0, it.gray};
              r.byte_count = BYTES_NARROW;
            end
            results_due.push_back(r);
          end
        end
      end
      OP_FRAME: begin
        r.kind = KIND_FRAME;
        r.box_left = box_l[BOX_W-1:0];
        r.box_top = box_t[BOX_W-1:0];
        r.box_right = box_r[BOX_W-1:0];
        r.box_bottom = box_b[BOX_W-1:0];
        r.box_empty = (box_l >= box_r) || (box_t >= box_b);
        r.frame_dirty = dirty_seen;
        results_due.push_back(r);
        box_l = scr_w;
        box_t = scr_h;
        box_r = 0;
        box_b = 0;
        dirty_seen = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  function automatic string describe(input blit_result_t r);
    return $sformatf("kind=%0d addr=%h data=%h bytes=%0d box=%0d,%0d,%0d,%0d empty=%0d dirty=%0d",
                     r.kind, r.address, r.data, r.byte_count, r.box_left, r.box_top,
                     r.box_right, r.box_bottom, r.box_empty, r.frame_dirty);
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) composite(on_bus);
      if (!in_ch.valid || in_ch.ready) begin
        if (items_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = items_pending.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.op <= on_bus.op;
          in_ch.win_x <= on_bus.win_x;
          in_ch.win_y <= on_bus.win_y;
          in_ch.win_w <= on_bus.win_w;
          in_ch.win_h <= on_bus.win_h;
          in_ch.win_dirty <= on_bus.win_dirty;
          in_ch.gray <= on_bus.gray;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen.kind = out_ch.kind;
        seen.address = out_ch.address;
        seen.data = out_ch.data;
        seen.byte_count = out_ch.byte_count;
        seen.box_left = out_ch.box_left;
        seen.box_top = out_ch.box_top;
        seen.box_right = out_ch.box_right;
        seen.box_bottom = out_ch.box_bottom;
        seen.box_empty = out_ch.box_empty;
        seen.frame_dirty = out_ch.frame_dirty;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected transfer: %s", describe(seen));
        end else begin
          wanted = results_due.pop_front();
          if (seen !== wanted) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch: expected %s", describe(wanted));
              $display("          actual   %s", describe(seen));
            end
          end
        end
      end
      out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic blit_item_t random_item();
    blit_item_t it;
    it.op = 2'($urandom_range(3));
    it.win_x = POS_W'($urandom_range(16'hFFFF));
    it.win_y = POS_W'($urandom_range(16'hFFFF));
    it.win_w = BOX_W'($urandom_range(4096));
    it.win_h = BOX_W'($urandom_range(4096));
    it.win_dirty = 1'($urandom_range(1));
    it.gray = GRAY_W'($urandom_range(255));
    return it;
  endfunction

  task automatic push_item(input logic [1:0] op, input int x, input int y, input int w,
                           input int h, input bit dirty, input int gray);
    blit_item_t it;
    it.op = op;
    it.win_x = x[POS_W-1:0];
    it.win_y = y[POS_W-1:0];
    it.win_w = w[BOX_W-1:0];
    it.win_h = h[BOX_W-1:0];
    it.win_dirty = dirty;
    it.gray = gray[GRAY_W-1:0];
    items_pending.push_back(it);
  endtask

  function automatic int pick_size();
    int sel;
    sel = $urandom_range(19);
    if (sel == 0) return 4096;
    if (sel == 1) return 4095;
    if (sel == 2) return 0;
    return $urandom_range(1, 9);
  endfunction

  function automatic int queue_window(input bit wild);
    blit_item_t it;
    int w, h, n, k, span;
    w = pick_size();
    h = pick_size();
    it = random_item();
    it.op = OP_HEADER;
    it.win_w = w[BOX_W-1:0];
    it.win_h = h[BOX_W-1:0];
    if (!wild) begin
      span = imin(w, 16) + 2;
      k = $urandom_range(0, scr_w + 2 * span) - span;
      it.win_x = k[POS_W-1:0];
      span = imin(h, 16) + 2;
      k = $urandom_range(0, scr_h + 2 * span) - span;
      it.win_y = k[POS_W-1:0];
    end
    items_pending.push_back(it);
    n = (w * h > 60) ? $urandom_range(1, 60) : w * h;
    k = $urandom_range(99);
    if (wild) n = $urandom_range(0, 5);
    else if (k < 8) n = $urandom_range(0, n);
    else if (k < 15) n = n + $urandom_range(1, 3);
    for (k = 0; k < n; k++) begin
      it = random_item();
      it.op = OP_PIXEL;
      items_pending.push_back(it);
    end
    return n + 1;
  endfunction

  task automatic queue_random(input int count);
    blit_item_t it;
    int made, r;
    made = 0;
    while (made < count) begin
      r = $urandom_range(99);
      if (r < 72) begin
        made += queue_window(1'b0);
      end else if (r < 84) begin
        it = random_item();
        it.op = OP_FRAME;
        items_pending.push_back(it);
        made++;
      end else if (r < 90) begin
        it = random_item();
        it.op = OP_PIXEL;
        items_pending.push_back(it);
        made++;
      end else if (r < 94) begin
        it = random_item();
        it.op = OP_UNUSED;
        items_pending.push_back(it);
        made++;
      end else begin
        made += queue_window(1'b1);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    logic [CFG_DATA_W-1:0] word;
    word = val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= word;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_SCREEN_W: scr_w = word[BOX_W-1:0];
      CFG_SCREEN_H: scr_h = word[BOX_W-1:0];
      CFG_STRIDE:   stride = word[STRIDE_W-1:0];
      CFG_WIDE:     wide = word[0];
      default: begin
      end
    endcase
  endtask

  task automatic set_screen(input int w, input int h, input int s, input bit wd);
    write_reg(CFG_SCREEN_W, w);
    write_reg(CFG_SCREEN_H, h);
    write_reg(CFG_STRIDE, s);
    write_reg(CFG_WIDE, wd);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(posedge clk);
    send_idle_pct <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  task automatic drain();
    while (items_pending.size() != 0 || in_ch.valid || results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_HEADER;
    in_ch.win_x = '0;
    in_ch.win_y = '0;
    in_ch.win_w = '0;
    in_ch.win_h = '0;
    in_ch.win_dirty = 1'b0;
    in_ch.gray = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    push_item(OP_FRAME, 0, 0, 0, 0, 1'b0, 0);
    push_item(OP_PIXEL, 0, 0, 0, 0, 1'b0, 8'h5A);
    push_item(OP_UNUSED, -1, -1, 4096, 4096, 1'b1, 255);
    push_item(OP_HEADER, -1, -1, 3, 2, 1'b1, 0);
    push_item(OP_PIXEL, 0, 0, 0, 0, 1'b0, 0);
    push_item(OP_PIXEL, 0, 0, 0, 0, 1'b0, 255);
    push_item(OP_PIXEL, 0, 0, 0, 0, 1'b0, 1);
    push_item(OP_PIXEL, 0, 0, 0, 0, 1'b0, 128);
    push_item(OP_PIXEL, 0, 0, 0, 0, 1'b0, 254);
    push_item(OP_PIXEL, 0, 0, 0, 0, 1'b0, 127);
    push_item(OP_HEADER, 638, 479, 4, 2, 1'b0, 0);
    push_item(OP_PIXEL, 0, 0, 0, 0, 1'b0, 8'hA5);
    push_item(OP_PIXEL, 0, 0, 0, 0, 1'b0, 8'h3C);
    push_item(OP_PIXEL, 0, 0, 0, 0, 1'b0, 8'hC3);
    push_item(OP_HEADER, 32767, -32768, 4096, 4096, 1'b0, 0);
    push_item(OP_PIXEL, 0, 0, 0, 0, 1'b0, 7);
    push_item(OP_PIXEL, 0, 0, 0, 0, 1'b0, 9);
    push_item(OP_HEADER, -32768, 32767, 0, 4096, 1'b1, 0);
    push_item(OP_PIXEL, 0, 0, 0, 0, 1'b0, 11);
    push_item(OP_FRAME, 0, 0, 0, 0, 1'b0, 0);
    push_item(OP_HEADER, 5, 5, 2, 1, 1'b0, 0);
    push_item(OP_PIXEL, 0, 0, 0, 0, 1'b0, 200);
    push_item(OP_PIXEL, 0, 0, 0, 0, 1'b0, 100);
    push_item(OP_PIXEL, 0, 0, 0, 0, 1'b0, 50);
    push_item(OP_FRAME, 0, 0, 0, 0, 1'b0, 0);
    push_item(OP_FRAME, 0, 0, 0, 0, 1'b0, 0);
    drain();

    set_screen(4096, 4096, 32767, 1'b1);
    queue_random(220);
    fork
      begin
        @(posedge clk);
        recv_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        recv_hold <= 1'b0;
      end
    join_none
    drain();

    set_screen(1, 1, 1, 1'b0);
    set_idling(74, 0);
    queue_random(150);
    drain();

    set_screen(37, 23, 16384, 1'b0);
    set_idling(0, 74);
    queue_random(300);
    drain();

    set_screen(0, 0, 100, 1'b1);
    set_idling(25, 25);
    queue_random(100);
    drain();

    set_screen(200, 150, 800, 1'b1);
    queue_random(300);
    drain();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
